// ===== hw/rtl/assert_macros.svh =====
// Assertion shorthands for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define REWB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define REWB_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/rewb_pkg.sv =====
package rewb_pkg;

   // Default widths for the top level parameters
   localparam int DEFAULT_DELTA_BITS = 8;
   localparam int DEFAULT_TIME_BITS  = 32;

   // Configuration port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam int STEPS_BITS     = 3;
   localparam int MS_CFG_BITS    = 16;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_STEPS    = 2'd0,
      CSR_DEBOUNCE = 2'd1,
      CSR_HOLD     = 2'd2
   } csr_index_type;

   localparam logic [STEPS_BITS-1:0]  STEPS_RESET    = 3'd4;
   localparam logic [MS_CFG_BITS-1:0] DEBOUNCE_RESET = 16'd30;
   localparam logic [MS_CFG_BITS-1:0] HOLD_RESET     = 16'd600;

   // Steps per detent are clamped to 1..4
   localparam logic [STEPS_BITS-1:0] STEPS_MIN = 3'd1;
   localparam logic [STEPS_BITS-1:0] STEPS_MAX = 3'd4;

   // Button event codes
   typedef enum logic [1:0] {
      EV_NONE  = 2'd0,
      EV_CLICK = 2'd1,
      EV_HOLD  = 2'd2
   } event_type;

   // Configuration registers as seen by the datapath
   typedef struct packed {
      logic [STEPS_BITS-1:0]  steps;
      logic [MS_CFG_BITS-1:0] debounce_ms;
      logic [MS_CFG_BITS-1:0] hold_ms;
   } cfg_type;

   // Quadrature direction from {previous phase, new phase}.
   // Phase is {b, a}; 0->1->3->2->0 counts down, the reverse counts up,
   // no change and two-bit jumps count nothing.
   function automatic logic signed [1:0] quad_dir(input logic [3:0] idx);
      logic signed [1:0] dir;
      dir = 2'sd0;
      case (idx) inside
         4'd2, 4'd4, 4'd11, 4'd13: dir = 2'sd1;
         4'd1, 4'd7, 4'd8, 4'd14:  dir = -2'sd1;
         default:                  dir = 2'sd0;
      endcase
      return dir;
   endfunction

endpackage

// ===== hw/rtl/rotary_encoder_with_button.sv =====
// Rotary encoder front end: decodes quadrature steps into detents and
// debounces the push button into click and hold events. One sample is
// accepted per clock while req_stall is low. The decode logic sits between
// the input and result registers, so a poll answer passes through both
// before it shows on the result channel. Samples without poll give no
// result. The input register only holds when a poll sample meets a full,
// stalled result register. The millisecond timer counts sample ms_tick flags.
module rotary_encoder_with_button #(
   parameter int DELTA_BITS = rewb_pkg::DEFAULT_DELTA_BITS,
   parameter int TIME_BITS  = rewb_pkg::DEFAULT_TIME_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // sample channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_phase_a,
   input  logic                                 req_phase_b,
   input  logic                                 req_button_down,
   input  logic                                 req_ms_tick,
   input  logic                                 req_poll,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [DELTA_BITS-1:0]         rsp_detent_delta,
   output logic [1:0]                           rsp_button_event,
   // configuration
   input  logic                                 csr_we,
   input  logic [rewb_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [rewb_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import rewb_pkg::*;

   cfg_type cfg_ff, cfg_in;

   logic       in_valid_ff, in_valid_in;
   logic [1:0] in_phase_ff;
   logic       in_down_ff;
   logic       in_tick_ff;
   logic       in_poll_ff;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [DELTA_BITS-1:0] rsp_delta_ff;
   event_type                    rsp_event_ff;

   logic                         take;
   logic                         out_free;
   logic                         advance;
   logic                         report;
   logic signed [DELTA_BITS-1:0] count_now;
   event_type                    btn_event;

   // Configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_STEPS:    cfg_in.steps       = csr_wdata[STEPS_BITS-1:0];
            CSR_DEBOUNCE: cfg_in.debounce_ms = csr_wdata[MS_CFG_BITS-1:0];
            CSR_HOLD:     cfg_in.hold_ms     = csr_wdata[MS_CFG_BITS-1:0];
            default:      cfg_in             = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.steps       <= STEPS_RESET;
         cfg_ff.debounce_ms <= DEBOUNCE_RESET;
         cfg_ff.hold_ms     <= HOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Flow control: a sample moves on unless it is a poll facing a held result
   always_comb begin
      out_free     = !rsp_valid_ff || !rsp_stall;
      advance      = in_valid_ff && (!in_poll_ff || out_free);
      report       = advance && in_poll_ff;
      req_stall    = in_valid_ff && !advance;
      take         = req_valid && !req_stall;
      in_valid_in  = take || (in_valid_ff && !advance);
      rsp_valid_in = report || (rsp_valid_ff && rsp_stall);
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_phase_ff <= {req_phase_b, req_phase_a};
         in_down_ff  <= req_button_down;
         in_tick_ff  <= req_ms_tick;
         in_poll_ff  <= req_poll;
      end
   end

   rewb_quad #(
      .DELTA_BITS (DELTA_BITS)
   ) u_quad (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .phase     (in_phase_ff),
      .poll      (in_poll_ff),
      .cfg       (cfg_ff),
      .count_now (count_now)
   );

   rewb_button #(
      .TIME_BITS (TIME_BITS)
   ) u_button (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .ms_tick   (in_tick_ff),
      .step      (report && (count_now == '0)),
      .down      (in_down_ff),
      .cfg       (cfg_ff),
      .btn_event (btn_event)
   );

   // Result register: detents take priority over the button
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (report) begin
         rsp_delta_ff <= count_now;
         rsp_event_ff <= (count_now != '0) ? EV_NONE : btn_event;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_detent_delta = rsp_delta_ff;
   assign rsp_button_event = rsp_event_ff;

endmodule

// ===== hw/rtl/rewb_quad.sv =====
module rewb_quad #(
   parameter int DELTA_BITS = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic [1:0]                   phase,
   input  logic                         poll,
   input  rewb_pkg::cfg_type            cfg,
   output logic signed [DELTA_BITS-1:0] count_now
);
   import rewb_pkg::*;

   localparam logic signed [DELTA_BITS-1:0] DMAX = {1'b0, {(DELTA_BITS-1){1'b1}}};
   localparam logic signed [DELTA_BITS-1:0] DMIN = {1'b1, {(DELTA_BITS-1){1'b0}}};

   logic [1:0]                   last_phase_ff, last_phase_in;
   logic                         seeded_ff, seeded_in;
   logic signed [2:0]            partial_ff, partial_in;
   logic signed [DELTA_BITS-1:0] count_ff, count_in;

   logic signed [1:0]     dir;
   logic [STEPS_BITS-1:0] spd_u;
   logic signed [3:0]     spd;
   logic signed [3:0]     sum;
   logic                  step_up;
   logic                  step_dn;

   // Direction of this sample; first sample only seeds the phase
   always_comb begin
      dir = seeded_ff ? quad_dir({last_phase_ff, phase}) : 2'sd0;
      if (cfg.steps < STEPS_MIN) begin
         spd_u = STEPS_MIN;
      end else if (cfg.steps > STEPS_MAX) begin
         spd_u = STEPS_MAX;
      end else begin
         spd_u = cfg.steps;
      end
      spd     = $signed({1'b0, spd_u});
      sum     = $signed({partial_ff[2], partial_ff}) + $signed({{2{dir[1]}}, dir});
      step_up = (dir != 2'sd0) && (sum >= spd);
      step_dn = (dir != 2'sd0) && (sum <= -spd);
   end

   // Partial step count and saturating detent count
   always_comb begin
      last_phase_in = phase;
      seeded_in     = 1'b1;
      if (step_up || step_dn) begin
         partial_in = 3'sd0;
      end else if (dir != 2'sd0) begin
         partial_in = sum[2:0];
      end else begin
         partial_in = partial_ff;
      end
      count_now = count_ff;
      if (step_up && (count_ff != DMAX)) begin
         count_now = count_ff + DELTA_BITS'(1);
      end else if (step_dn && (count_ff != DMIN)) begin
         count_now = count_ff - DELTA_BITS'(1);
      end
      // a poll reports and clears a nonzero count
      count_in = (poll && (count_now != '0)) ? '0 : count_now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_phase_ff <= 2'd0;
         seeded_ff     <= 1'b0;
         partial_ff    <= 3'sd0;
         count_ff      <= '0;
      end else if (advance) begin
         last_phase_ff <= last_phase_in;
         seeded_ff     <= seeded_in;
         partial_ff    <= partial_in;
         count_ff      <= count_in;
      end
   end

endmodule

// ===== hw/rtl/rewb_button.sv =====
module rewb_button #(
   parameter int TIME_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                ms_tick,
   input  logic                step,
   input  logic                down,
   input  rewb_pkg::cfg_type   cfg,
   output rewb_pkg::event_type btn_event
);
   import rewb_pkg::*;

   typedef enum logic [3:0] {
      BTN_IDLE  = 4'b0001,
      BTN_MAYBE = 4'b0010,
      BTN_ARMED = 4'b0100,
      BTN_HOLD  = 4'b1000
   } btn_state_type;

   btn_state_type        state_ff, state_in;
   logic [TIME_BITS-1:0] ms_ff, ms_in;
   logic [TIME_BITS-1:0] mark_ff, mark_in;
   logic [TIME_BITS-1:0] elapsed;

   // Millisecond clock advances before the button is looked at
   always_comb begin
      ms_in   = ms_ff + TIME_BITS'(ms_tick);
      elapsed = ms_in - mark_ff;
   end

   // Button machine, stepped only on polls that report no detents
   always_comb begin
      state_in  = state_ff;
      mark_in   = mark_ff;
      btn_event = EV_NONE;
      unique case (state_ff)
         BTN_IDLE: begin
            if (down) begin
               mark_in  = ms_in;
               state_in = BTN_MAYBE;
            end
         end
         BTN_MAYBE: begin
            if (!down) begin
               state_in = BTN_IDLE;
            end else if (elapsed >= TIME_BITS'(cfg.debounce_ms)) begin
               state_in = BTN_ARMED;
               mark_in  = ms_in;
            end
         end
         BTN_ARMED: begin
            if (!down) begin
               state_in  = BTN_IDLE;
               btn_event = EV_CLICK;
            end else if (elapsed > TIME_BITS'(cfg.hold_ms)) begin
               state_in  = BTN_HOLD;
               btn_event = EV_HOLD;
            end
         end
         BTN_HOLD: begin
            if (!down) begin
               state_in = BTN_IDLE;
            end
         end
         default: begin
            state_in = BTN_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BTN_IDLE;
         ms_ff    <= '0;
         mark_ff  <= '0;
      end else if (advance) begin
         ms_ff <= ms_in;
         if (step) begin
            state_ff <= state_in;
            mark_ff  <= mark_in;
         end
      end
   end

endmodule

// ===== hw/rtl/rewb_checker.sv =====
`include "assert_macros.svh"

module rewb_checker #(
   parameter int DELTA_BITS = 8
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [DELTA_BITS-1:0] rsp_detent_delta,
   input logic [1:0]            rsp_button_event
);
   import rewb_pkg::*;

   logic                  req_idle;
   logic                  held;
   logic                  one_kind;
   logic                  code_ok;
   logic [DELTA_BITS+1:0] payload;

   assign req_idle = !req_valid && !req_stall;
   assign held     = rsp_valid && rsp_stall;
   assign one_kind = (rsp_detent_delta == '0) || (rsp_button_event == EV_NONE);
   assign code_ok  = (rsp_button_event == EV_NONE) || (rsp_button_event == EV_CLICK) ||
                     (rsp_button_event == EV_HOLD);
   assign payload  = {rsp_detent_delta, rsp_button_event};

   // Result register comes out of reset empty
   `REWB_ASSERT_ALWAYS(a_rst_empty, clock, reset |=> !rsp_valid, "result valid after reset")

   // With nothing offered and nothing held, the input stays open
   `REWB_ASSERT(a_idle_ready, clock, reset, req_idle |=> !req_stall, "stall with no sample")

   // A result reports either detents or the button, never both
   `REWB_ASSERT(a_one_kind, clock, reset, rsp_valid |-> one_kind, "detents and event together")

   // Only the defined event codes appear
   `REWB_ASSERT(a_event_code, clock, reset, rsp_valid |-> code_ok, "undefined event code")

   // A stalled result holds
   `REWB_ASSERT(a_rsp_hold, clock, reset, held |=> rsp_valid && $stable(payload), "held result moved")

endmodule

bind rotary_encoder_with_button rewb_checker #(
   .DELTA_BITS (DELTA_BITS)
) u_rewb_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_detent_delta (rsp_detent_delta),
   .rsp_button_event (rsp_button_event)
);
